@@ rtl/brtc_pkg.sv @@
package brtc_pkg;

  typedef enum logic [2:0] {
    REQ_TICK     = 3'd0,
    REQ_WR_START = 3'd1,
    REQ_RD_START = 3'd2,
    REQ_WR_BYTE  = 3'd3,
    REQ_RD_BYTE  = 3'd4
  } req_e;

  // Register map
  localparam logic [7:0] ADDR_SEC     = 8'h00;
  localparam logic [7:0] ADDR_MIN     = 8'h01;
  localparam logic [7:0] ADDR_HOUR    = 8'h02;
  localparam logic [7:0] ADDR_WDAY    = 8'h03;
  localparam logic [7:0] ADDR_DAY     = 8'h04;
  localparam logic [7:0] ADDR_MONTH   = 8'h05;
  localparam logic [7:0] ADDR_YEAR    = 8'h06;
  localparam logic [7:0] ADDR_CTRL    = 8'h0e;
  localparam logic [7:0] ADDR_STATUS  = 8'h0f;
  localparam logic [7:0] ADDR_TEMP    = 8'h11;

  localparam logic [7:0] CTRL_VALUE   = 8'h1c;
  localparam logic [7:0] TEMP_VALUE   = 8'd25;
  localparam logic [7:0] CENTURY_BIT  = 8'h80;

  localparam logic [15:0] YEAR_BASE    = 16'd2000;
  localparam logic [15:0] CENTURY_YEAR = 16'd2100;

  // Reset values
  localparam logic [15:0] RST_YEAR    = 16'd2026;
  localparam logic [6:0]  RST_YEAR_LO = 7'd26;
  localparam logic [7:0]  RST_MONTH   = 8'd7;
  localparam logic [7:0]  RST_DAY     = 8'd22;
  localparam logic [7:0]  RST_HOUR    = 8'd12;
  localparam logic [7:0]  RST_WDAY    = 8'd4;
  localparam logic [7:0]  RST_STATUS  = 8'h80;

  typedef struct packed {
    logic       go;
    logic [2:0] req_type;
    logic [7:0] data_byte;
  } cmd_t;

  // v + 6*(v/10), v/10 via multiply by 205 and shift by 11 (exact for 8 bits)
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [15:0] p;
    logic [4:0]  q;
    p = {8'd0, v} * 16'd205;
    q = p[15:11];
    return v + 8'({3'd0, q} * 8'd6);
  endfunction

  function automatic logic [7:0] from_bcd(input logic [7:0] v);
    return v - 8'({4'd0, v[7:4]} * 8'd6);
  endfunction

  // (v mod 7) + 1, v/7 via multiply by 293 and shift by 11
  function automatic logic [7:0] wday_next(input logic [7:0] v);
    logic [16:0] p;
    logic [5:0]  q;
    p = {9'd0, v} * 17'd293;
    q = p[16:11];
    return v - 8'({2'd0, q} * 8'd7) + 8'd1;
  endfunction

  function automatic logic [7:0] days_in(input logic [7:0] m, input logic leap);
    logic [7:0] n;
    case (m)
      8'd2:  n = leap ? 8'd29 : 8'd28;
      8'd4:  n = 8'd30;
      8'd6:  n = 8'd30;
      8'd9:  n = 8'd30;
      8'd11: n = 8'd30;
      default: n = 8'd31;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/brtc_req_if.sv @@
interface brtc_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

@@ rtl/brtc_rsp_if.sv @@
interface brtc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink (input valid, input read_data, output ready);
endinterface

@@ rtl/brtc_regs.sv @@
module brtc_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  brtc_pkg::cmd_t    cmd_i,
  output logic [7:0]        rd_data_o
);

  logic [7:0]  ptr_q, ptr_d;
  logic        expect_q, expect_d;
  logic [15:0] year_q, year_d;
  logic [6:0]  year_lo_q, year_lo_d;   // year mod 100, tracked alongside the year
  logic [7:0]  month_q, month_d;
  logic [7:0]  day_q, day_d;
  logic [7:0]  hour_q, hour_d;
  logic [7:0]  min_q, min_d;
  logic [7:0]  sec_q, sec_d;
  logic [7:0]  wday_q, wday_d;
  logic [7:0]  status_q, status_d;

  logic [7:0]  sec_inc, min_inc, hour_inc, day_inc, month_inc;
  logic        c_sec, c_min, c_hour, c_day, c_month;
  logic        leap;
  logic [7:0]  wr_val;
  logic [7:0]  year_u;
  logic [7:0]  rd_val;

  assign leap = (year_q[1:0] == 2'd0 && year_lo_q != 7'd0) ||
                (year_lo_q == 7'd0 && year_q[3:0] == 4'd0);

  assign sec_inc   = sec_q + 8'd1;
  assign min_inc   = min_q + 8'd1;
  assign hour_inc  = hour_q + 8'd1;
  assign day_inc   = day_q + 8'd1;
  assign month_inc = month_q + 8'd1;

  assign c_sec   = sec_inc >= 8'd60;
  assign c_min   = c_sec && (min_inc >= 8'd60);
  assign c_hour  = c_min && (hour_inc >= 8'd24);
  assign c_day   = c_hour && (day_inc > brtc_pkg::days_in(month_q, leap));
  assign c_month = c_day && (month_inc > 8'd12);

  assign year_u = brtc_pkg::from_bcd(cmd_i.data_byte);

  always_comb begin
    case (ptr_q)
      brtc_pkg::ADDR_SEC:    rd_val = brtc_pkg::to_bcd(sec_q);
      brtc_pkg::ADDR_MIN:    rd_val = brtc_pkg::to_bcd(min_q);
      brtc_pkg::ADDR_HOUR:   rd_val = brtc_pkg::to_bcd(hour_q);
      brtc_pkg::ADDR_WDAY:   rd_val = wday_q;
      brtc_pkg::ADDR_DAY:    rd_val = brtc_pkg::to_bcd(day_q);
      brtc_pkg::ADDR_MONTH:  rd_val = brtc_pkg::to_bcd(month_q) |
                               ((year_q >= brtc_pkg::CENTURY_YEAR) ?
                                brtc_pkg::CENTURY_BIT : 8'h00);
      brtc_pkg::ADDR_YEAR:   rd_val = brtc_pkg::to_bcd({1'b0, year_lo_q});
      brtc_pkg::ADDR_CTRL:   rd_val = brtc_pkg::CTRL_VALUE;
      brtc_pkg::ADDR_STATUS: rd_val = status_q;
      brtc_pkg::ADDR_TEMP:   rd_val = brtc_pkg::TEMP_VALUE;
      default:               rd_val = 8'h00;
    endcase
  end

  always_comb begin
    ptr_d     = ptr_q;
    expect_d  = expect_q;
    year_d    = year_q;
    year_lo_d = year_lo_q;
    month_d   = month_q;
    day_d     = day_q;
    hour_d    = hour_q;
    min_d     = min_q;
    sec_d     = sec_q;
    wday_d    = wday_q;
    status_d  = status_q;
    wr_val    = cmd_i.data_byte;
    rd_data_o = 8'h00;

    if (cmd_i.go) begin
      case (cmd_i.req_type)
        brtc_pkg::REQ_TICK: begin
          sec_d = c_sec ? 8'd0 : sec_inc;
          if (c_sec) min_d = c_min ? 8'd0 : min_inc;
          if (c_min) hour_d = c_hour ? 8'd0 : hour_inc;
          if (c_hour) begin
            wday_d = brtc_pkg::wday_next(wday_q);
            day_d  = c_day ? 8'd1 : day_inc;
          end
          if (c_day) month_d = c_month ? 8'd1 : month_inc;
          if (c_month) begin
            year_d = year_q + 16'd1;
            // keep the mod-100 shadow consistent with the 16-bit wrap
            if (year_q == 16'hffff || year_lo_q == 7'd99) year_lo_d = 7'd0;
            else year_lo_d = year_lo_q + 7'd1;
          end
        end
        brtc_pkg::REQ_WR_START: expect_d = 1'b1;
        brtc_pkg::REQ_WR_BYTE: begin
          if (expect_q) begin
            ptr_d    = cmd_i.data_byte;
            expect_d = 1'b0;
          end else begin
            ptr_d = ptr_q + 8'd1;
            case (ptr_q)
              brtc_pkg::ADDR_SEC:    sec_d = brtc_pkg::from_bcd(wr_val & 8'h7f);
              brtc_pkg::ADDR_MIN:    min_d = brtc_pkg::from_bcd(wr_val & 8'h7f);
              brtc_pkg::ADDR_HOUR:   hour_d = brtc_pkg::from_bcd(wr_val & 8'h3f);
              brtc_pkg::ADDR_WDAY:   wday_d = (wr_val == 8'd0) ? 8'd1 : wr_val;
              brtc_pkg::ADDR_DAY:    day_d = brtc_pkg::from_bcd(wr_val & 8'h3f);
              brtc_pkg::ADDR_MONTH:  month_d = brtc_pkg::from_bcd(wr_val & 8'h1f);
              brtc_pkg::ADDR_YEAR: begin
                year_d    = brtc_pkg::YEAR_BASE + {8'd0, year_u};
                year_lo_d = (year_u >= 8'd100) ? 7'(year_u - 8'd100) : year_u[6:0];
              end
              brtc_pkg::ADDR_STATUS: status_d = wr_val;
              default: ;
            endcase
          end
        end
        brtc_pkg::REQ_RD_BYTE: begin
          rd_data_o = rd_val;
          ptr_d     = ptr_q + 8'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= 8'd0;
      expect_q  <= 1'b0;
      year_q    <= brtc_pkg::RST_YEAR;
      year_lo_q <= brtc_pkg::RST_YEAR_LO;
      month_q   <= brtc_pkg::RST_MONTH;
      day_q     <= brtc_pkg::RST_DAY;
      hour_q    <= brtc_pkg::RST_HOUR;
      min_q     <= 8'd0;
      sec_q     <= 8'd0;
      wday_q    <= brtc_pkg::RST_WDAY;
      status_q  <= brtc_pkg::RST_STATUS;
    end else begin
      ptr_q     <= ptr_d;
      expect_q  <= expect_d;
      year_q    <= year_d;
      year_lo_q <= year_lo_d;
      month_q   <= month_d;
      day_q     <= day_d;
      hour_q    <= hour_d;
      min_q     <= min_d;
      sec_q     <= sec_d;
      wday_q    <= wday_d;
      status_q  <= status_d;
    end
  end

endmodule

@@ rtl/bcd_rtc_calendar_registers_top.sv @@
// A result is held in the output register, or parked in the skid entry while the
// output is stalled. Throughput: one request per cycle while input ready is high;
// a two-entry output buffer (output register plus skid) keeps the input open while
// one result waits. Input ready drops only while both entries are full.
// Reset (async, active low): time 12:00:00, 2026-07-22, weekday 4, status 0x80,
// register pointer 0, pointer capture disarmed, output buffer empty.
module bcd_rtc_calendar_registers_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  brtc_req_if.sink      req_i,
  brtc_rsp_if.source    rsp_o
);

  brtc_pkg::cmd_t cmd;
  logic [7:0]     rd_data;
  logic           accept;
  logic           out_fire;

  logic           out_vld_q, out_vld_d;
  logic [7:0]     out_data_q, out_data_d;
  logic           skid_vld_q, skid_vld_d;
  logic [7:0]     skid_data_q, skid_data_d;

  assign req_i.ready = !skid_vld_q;
  assign accept      = req_i.valid && req_i.ready;
  assign out_fire    = out_vld_q && rsp_o.ready;

  assign cmd.go        = accept;
  assign cmd.req_type  = req_i.req_type;
  assign cmd.data_byte = req_i.data_byte;

  brtc_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rd_data_o (rd_data)
  );

  always_comb begin
    out_vld_d   = out_vld_q;
    out_data_d  = out_data_q;
    skid_vld_d  = skid_vld_q;
    skid_data_d = skid_data_q;
    if (out_fire || !out_vld_q) begin
      if (skid_vld_q) begin
        // drain the skid entry first
        out_vld_d  = 1'b1;
        out_data_d = skid_data_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d  = accept;
        out_data_d = rd_data;
      end
    end else if (accept) begin
      // output stalled: park the new result
      skid_vld_d  = 1'b1;
      skid_data_d = rd_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.read_data = out_data_q;

  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held with empty output register");

  a_stall_parks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && out_vld_q && !rsp_o.ready) |=> skid_vld_q)
    else $error("result accepted during stall was not parked");

  a_skid_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && rsp_o.ready) |=> (!skid_vld_q && out_vld_q &&
                                     out_data_q == $past(skid_data_q)))
    else $error("skid entry not moved to output");

  a_accept_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_vld_q)
    else $error("accepted transaction produced no result");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;

  localparam int unsigned TARGET_ITEMS = 1650;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam logic [7:0]  TIME_MASK    = 8'h7f;
  localparam logic [7:0]  DAY_MASK     = 8'h3f;
  localparam logic [7:0]  MONTH_MASK   = 8'h1f;

  typedef struct {
    logic [15:0] year;
    logic [7:0]  month, day, hour, minute, second, wday, status, ptr;
    logic        ptr_armed;
  } rtc_state_t;

  logic clk;
  logic rst_n;

  brtc_req_if req_if ();
  brtc_rsp_if rsp_if ();

  bcd_rtc_calendar_registers_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  rtc_state_t  rtc;
  logic [7:0]  read_data_q[$];
  logic [7:0]  want_read_data;
  int unsigned items_sent      = 0;
  int unsigned mismatch_count  = 0;
  int unsigned cycle_count     = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned burst_left      = 0;
  bit          gaps_on         = 1'b0;

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] bin2bcd(input logic [15:0] v);
    logic [15:0] t;
    t = (v / 16'd10) * 16'd16 + v % 16'd10;
    return t[7:0];
  endfunction

  function automatic logic [7:0] bcd2bin(input logic [7:0] v);
    return 8'(v[7:4] * 10 + v[3:0]);
  endfunction

  function automatic logic [7:0] month_length(input logic [7:0] m, input logic [15:0] y);
    bit leap;
    leap = ((y % 16'd4 == 0) && (y % 16'd100 != 0)) || (y % 16'd400 == 0);
    case (m)
      8'd2:                    return leap ? 8'd29 : 8'd28;
      8'd4, 8'd6, 8'd9, 8'd11: return 8'd30;
      default:                 return 8'd31;
    endcase
  endfunction

  function automatic void reset_calendar();
    rtc.year      = brtc_pkg::RST_YEAR;
    rtc.month     = brtc_pkg::RST_MONTH;
    rtc.day       = brtc_pkg::RST_DAY;
    rtc.hour      = brtc_pkg::RST_HOUR;
    rtc.minute    = 8'd0;
    rtc.second    = 8'd0;
    rtc.wday      = brtc_pkg::RST_WDAY;
    rtc.status    = brtc_pkg::RST_STATUS;
    rtc.ptr       = 8'd0;
    rtc.ptr_armed = 1'b0;
  endfunction

  // Counters are 8 bits wide and wrap, so values above the limit may pass zero first
  function automatic void tick_calendar();
    rtc.second = rtc.second + 8'd1;
    if (rtc.second < 8'd60) return;
    rtc.second = 8'd0;
    rtc.minute = rtc.minute + 8'd1;
    if (rtc.minute < 8'd60) return;
    rtc.minute = 8'd0;
    rtc.hour = rtc.hour + 8'd1;
    if (rtc.hour < 8'd24) return;
    rtc.hour = 8'd0;
    rtc.wday = rtc.wday % 8'd7 + 8'd1;
    rtc.day = rtc.day + 8'd1;
    if (rtc.day <= month_length(rtc.month, rtc.year)) return;
    rtc.day = 8'd1;
    rtc.month = rtc.month + 8'd1;
    if (rtc.month <= 8'd12) return;
    rtc.month = 8'd1;
    rtc.year = rtc.year + 16'd1;
  endfunction

  function automatic logic [7:0] read_register(input logic [7:0] a);
    case (a)
      brtc_pkg::ADDR_SEC:    return bin2bcd({8'd0, rtc.second});
      brtc_pkg::ADDR_MIN:    return bin2bcd({8'd0, rtc.minute});
      brtc_pkg::ADDR_HOUR:   return bin2bcd({8'd0, rtc.hour});
      brtc_pkg::ADDR_WDAY:   return rtc.wday;
      brtc_pkg::ADDR_DAY:    return bin2bcd({8'd0, rtc.day});
      brtc_pkg::ADDR_MONTH:  return bin2bcd({8'd0, rtc.month}) |
                                    ((rtc.year >= brtc_pkg::CENTURY_YEAR) ?
                                     brtc_pkg::CENTURY_BIT : 8'h00);
      brtc_pkg::ADDR_YEAR:   return bin2bcd(rtc.year % 16'd100);
      brtc_pkg::ADDR_CTRL:   return brtc_pkg::CTRL_VALUE;
      brtc_pkg::ADDR_STATUS: return rtc.status;
      brtc_pkg::ADDR_TEMP:   return brtc_pkg::TEMP_VALUE;
      default:               return 8'h00;
    endcase
  endfunction

  function automatic void write_register(input logic [7:0] a, input logic [7:0] d);
    case (a)
      brtc_pkg::ADDR_SEC:    rtc.second = bcd2bin(d & TIME_MASK);
      brtc_pkg::ADDR_MIN:    rtc.minute = bcd2bin(d & TIME_MASK);
      brtc_pkg::ADDR_HOUR:   rtc.hour   = bcd2bin(d & DAY_MASK);
      brtc_pkg::ADDR_WDAY:   rtc.wday   = (d == 8'd0) ? 8'd1 : d;
      brtc_pkg::ADDR_DAY:    rtc.day    = bcd2bin(d & DAY_MASK);
      brtc_pkg::ADDR_MONTH:  rtc.month  = bcd2bin(d & MONTH_MASK);
      brtc_pkg::ADDR_YEAR:   rtc.year   = brtc_pkg::YEAR_BASE + {8'd0, bcd2bin(d)};
      brtc_pkg::ADDR_STATUS: rtc.status = d;
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] predict_read_data(input logic [2:0] req, input logic [7:0] d);
    logic [7:0] rd;
    rd = 8'h00;
    case (req)
      brtc_pkg::REQ_TICK:     tick_calendar();
      brtc_pkg::REQ_WR_START: rtc.ptr_armed = 1'b1;
      brtc_pkg::REQ_WR_BYTE: begin
        if (rtc.ptr_armed) begin
          rtc.ptr       = d;
          rtc.ptr_armed = 1'b0;
        end else begin
          write_register(rtc.ptr, d);
          rtc.ptr = rtc.ptr + 8'd1;
        end
      end
      brtc_pkg::REQ_RD_BYTE: begin
        rd      = read_register(rtc.ptr);
        rtc.ptr = rtc.ptr + 8'd1;
      end
      default: ;
    endcase
    return rd;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, timeout, response sink and checker
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned rx_mode;
    int unsigned rx_left;
    int unsigned phase;
    rsp_if.ready = 1'b0;
    rx_mode = 0;
    rx_left = 0;
    phase   = 0;
    forever begin
      @(negedge clk);
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 120);
      end
      rx_left--;
      phase++;
      if (hold_off_cycles != 0) begin
        rsp_if.ready = 1'b0;
        hold_off_cycles--;
      end else begin
        case (rx_mode)
          0:       rsp_if.ready = 1'b1;
          1:       rsp_if.ready = ($urandom_range(0, 3) != 0);
          2:       rsp_if.ready = ((phase % 5) >= 2);
          default: rsp_if.ready = ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (read_data_q.size() == 0) begin
        $error("read_data: no transaction pending, actual %02h", rsp_if.read_data);
        mismatch_count++;
      end else begin
        want_read_data = read_data_q.pop_front();
        if (rsp_if.read_data !== want_read_data) begin
          $error("read_data: expected %02h, actual %02h", want_read_data, rsp_if.read_data);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  task automatic idle_req(input int unsigned n);
    @(negedge clk);
    req_if.valid     = 1'b0;
    req_if.req_type  = 3'($urandom);
    req_if.data_byte = 8'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_req(input logic [2:0] req, input logic [7:0] d);
    @(negedge clk);
    req_if.valid     = 1'b1;
    req_if.req_type  = req;
    req_if.data_byte = d;
    do @(posedge clk); while (!req_if.ready);
    read_data_q.push_back(predict_read_data(req, d));
    if (req inside {brtc_pkg::REQ_TICK, brtc_pkg::REQ_WR_START, brtc_pkg::REQ_WR_BYTE,
                    brtc_pkg::REQ_RD_BYTE}) items_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        idle_req($urandom_range(1, 8));
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (read_data_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_pointer(input logic [7:0] a);
    send_req(brtc_pkg::REQ_WR_START, 8'($urandom));
    send_req(brtc_pkg::REQ_WR_BYTE, a);
  endtask

  function automatic logic [7:0] random_pointer();
    case ($urandom_range(0, 6))
      0:       return 8'($urandom);
      1:       return 8'($urandom_range(8'hfc, 8'hff));
      default: return 8'($urandom_range(0, 8'h12));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_readback();
    // pointer is zero out of reset: walk seconds through year
    repeat (7) send_req(brtc_pkg::REQ_RD_BYTE, 8'hff);
  endtask

  task automatic test_century_rollover();
    set_pointer(brtc_pkg::ADDR_SEC);
    send_req(brtc_pkg::REQ_WR_BYTE, 8'h59);
    send_req(brtc_pkg::REQ_WR_BYTE, 8'h59);
    send_req(brtc_pkg::REQ_WR_BYTE, 8'h23);
    send_req(brtc_pkg::REQ_WR_BYTE, 8'h00);  // zero weekday stores as one
    send_req(brtc_pkg::REQ_WR_BYTE, 8'h31);
    send_req(brtc_pkg::REQ_WR_BYTE, 8'h12);
    send_req(brtc_pkg::REQ_WR_BYTE, 8'h99);
    send_req(brtc_pkg::REQ_TICK, 8'h00);
    set_pointer(brtc_pkg::ADDR_WDAY);
    send_req(brtc_pkg::REQ_RD_START, 8'h00);
    repeat (4) send_req(brtc_pkg::REQ_RD_BYTE, 8'h00);
  endtask

  task automatic test_fixed_regs();
    set_pointer(brtc_pkg::ADDR_CTRL);
    repeat (4) send_req(brtc_pkg::REQ_RD_BYTE, 8'h00);
  endtask

  task automatic test_backpressure();
    wait_results_done();
    @(posedge clk);
    hold_off_cycles = 60;
    set_pointer(brtc_pkg::ADDR_SEC);
    repeat (24) send_req(brtc_pkg::REQ_RD_BYTE, 8'($urandom));
    wait_results_done();
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    logic [7:0]  yr_byte;
    logic [7:0]  mo_byte;
    logic [7:0]  mo_val;
    logic [7:0]  day_val;
    logic [15:0] yr_val;
    gaps_on = 1'b1;
    while (items_sent < TARGET_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        // register write transaction with mixed valid and raw bytes
        set_pointer(random_pointer());
        repeat ($urandom_range(1, 7))
          send_req(brtc_pkg::REQ_WR_BYTE,
                   ($urandom_range(0, 1) == 0) ? 8'($urandom)
                                               : bin2bcd(16'($urandom_range(0, 99))));
      end else if (pick < 45) begin
        set_pointer(random_pointer());
        if ($urandom_range(0, 1) == 0) send_req(brtc_pkg::REQ_RD_START, 8'($urandom));
        repeat ($urandom_range(1, 8)) send_req(brtc_pkg::REQ_RD_BYTE, 8'($urandom));
      end else if (pick < 70) begin
        // preset the clock just short of a rollover, tick it, then read back
        case ($urandom_range(0, 7))
          0:       yr_byte = 8'h00;
          1:       yr_byte = 8'h99;
          2:       yr_byte = 8'h96;
          3:       yr_byte = 8'h24;
          4:       yr_byte = 8'h23;
          5:       yr_byte = 8'ha0;
          6:       yr_byte = 8'($urandom);
          default: yr_byte = bin2bcd(16'($urandom_range(0, 99)));
        endcase
        mo_byte = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                              : bin2bcd(16'($urandom_range(1, 12)));
        yr_val  = brtc_pkg::YEAR_BASE + {8'd0, bcd2bin(yr_byte)};
        mo_val  = bcd2bin(mo_byte & MONTH_MASK);
        day_val = month_length(mo_val, yr_val) - 8'($urandom_range(0, 1));
        set_pointer(brtc_pkg::ADDR_SEC);
        send_req(brtc_pkg::REQ_WR_BYTE,
                 ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                             : bin2bcd(16'($urandom_range(50, 59))));
        send_req(brtc_pkg::REQ_WR_BYTE,
                 ($urandom_range(0, 4) == 0) ? bin2bcd(16'($urandom_range(0, 59)))
                                             : 8'h59);
        send_req(brtc_pkg::REQ_WR_BYTE, ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'h23);
        send_req(brtc_pkg::REQ_WR_BYTE,
                 ($urandom_range(0, 7) == 0) ? 8'hff : 8'($urandom_range(0, 8)));
        send_req(brtc_pkg::REQ_WR_BYTE,
                 ($urandom_range(0, 9) == 0) ? 8'($urandom) : bin2bcd({8'd0, day_val}));
        send_req(brtc_pkg::REQ_WR_BYTE, mo_byte);
        send_req(brtc_pkg::REQ_WR_BYTE, yr_byte);
        repeat ($urandom_range(1, 12)) send_req(brtc_pkg::REQ_TICK, 8'($urandom));
        set_pointer(brtc_pkg::ADDR_SEC);
        send_req(brtc_pkg::REQ_RD_START, 8'($urandom));
        repeat (7) send_req(brtc_pkg::REQ_RD_BYTE, 8'($urandom));
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 30)) send_req(brtc_pkg::REQ_TICK, 8'($urandom));
      end else begin
        // noise: any request code, including the unused ones
        repeat ($urandom_range(1, 6)) send_req(3'($urandom), 8'($urandom));
      end
      if ($urandom_range(0, 39) == 0) wait_results_done();
    end
    gaps_on = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    req_if.valid     = 1'b0;
    req_if.req_type  = 3'd0;
    req_if.data_byte = 8'd0;
    reset_calendar();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_reset_readback();
    test_century_rollover();
    test_fixed_regs();
    test_backpressure();
    test_random_traffic();

    wait_results_done();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/brtc_pkg.sv
rtl/brtc_req_if.sv
rtl/brtc_rsp_if.sv
rtl/brtc_regs.sv
rtl/bcd_rtc_calendar_registers_top.sv
verif/tb_top.sv
